// File: hw/rtl/ddcf_pkg.sv
package ddcf_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned HANDLE_W    = 32;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PEND_W      = 6;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned ENTRY_W     = 2 * HANDLE_W;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;

  localparam logic [PRIO_W-1:0] PRIO_LOW  = PRIO_W'(4);
  localparam logic [PRIO_W-1:0] PRIO_HIGH = PRIO_W'(31);

  typedef enum logic {
    OP_QUEUE    = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN_RD,
    S_DRAIN_WR,
    S_EMIT
  } state_e;

  typedef struct packed {
    status_e              status;
    logic                 was_duplicate;
    logic [HANDLE_W-1:0]  out_procedure;
    logic [HANDLE_W-1:0]  out_context;
    logic                 last_of_run;
    logic [PEND_W-1:0]    pending_now;
    logic [TOTAL_W-1:0]   total_queued;
    logic [TOTAL_W-1:0]   total_dispatched;
  } rsp_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ddcf_req_if.sv
interface ddcf_req_if import ddcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [PRIO_W-1:0]   priority_level;
  logic [HANDLE_W-1:0] procedure_id;
  logic [HANDLE_W-1:0] context_id;

  modport source (
    output valid, operation, priority_level, procedure_id, context_id,
    input  ready
  );
  modport sink (
    input  valid, operation, priority_level, procedure_id, context_id,
    output ready
  );
endinterface

// File: hw/rtl/ddcf_rsp_if.sv
interface ddcf_rsp_if import ddcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                was_duplicate;
  logic [HANDLE_W-1:0] out_procedure;
  logic [HANDLE_W-1:0] out_context;
  logic                last_of_run;
  logic [PEND_W-1:0]   pending_now;
  logic [TOTAL_W-1:0]  total_queued;
  logic [TOTAL_W-1:0]  total_dispatched;

  modport source (
    output valid, status, was_duplicate, out_procedure, out_context, last_of_run,
           pending_now, total_queued, total_dispatched,
    input  ready
  );
  modport sink (
    input  valid, status, was_duplicate, out_procedure, out_context, last_of_run,
           pending_now, total_queued, total_dispatched,
    output ready
  );
endinterface

// File: hw/rtl/ddcf_ram.sv
module ddcf_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ddcf_ctrl.sv
module ddcf_ctrl import ddcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddcf_req_if.sink    req,
  ddcf_rsp_if.source  rsp
);

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TOTAL_W-1:0]  tq_q, tq_d, td_q, td_d;
  logic [CNT_W-1:0]    scan_cnt_q, scan_cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic                match_q, match_d;
  logic [HANDLE_W-1:0] proc_q, proc_d, ctx_q, ctx_d;
  status_e             status_q, status_d;
  logic                dup_q, dup_d;
  logic                append_q, append_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  logic                ram_we, ram_re;
  logic [PTR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]    scan_sum;
  logic [PTR_W-1:0]    scan_addr;
  logic                out_free;

  ddcf_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({proc_q, ctx_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Position of the scanned entry, counted from the oldest one, with wrap.
  always_comb begin
    scan_sum = {1'b0, rp_q} + SUM_W'(scan_cnt_q);
    if (scan_sum >= SUM_W'(QUEUE_DEPTH)) begin
      scan_sum = scan_sum - SUM_W'(QUEUE_DEPTH);
    end
    scan_addr = scan_sum[PTR_W-1:0];
  end

  assign out_free  = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    tq_d        = tq_q;
    td_d        = td_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = rd_vld_q;
    match_d     = match_q;
    proc_d      = proc_q;
    ctx_d       = ctx_q;
    status_d    = status_q;
    dup_d       = dup_q;
    append_d    = append_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rp_q;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          proc_d   = req.procedure_id;
          ctx_d    = req.context_id;
          dup_d    = 1'b0;
          append_d = 1'b0;
          if (req.operation == OP_DISPATCH) begin
            if (cnt_q == '0) begin
              status_d = ST_NONE;
              state_d  = S_EMIT;
            end else begin
              state_d = S_DRAIN_RD;
            end
          end else if (req.procedure_id == '0 || req.priority_level < PRIO_LOW ||
                       req.priority_level > PRIO_HIGH) begin
            status_d = ST_INVALID;
            state_d  = S_EMIT;
          end else if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_EMIT;
          end else if (cnt_q == '0) begin
            status_d = ST_OK;
            append_d = 1'b1;
            state_d  = S_EMIT;
          end else begin
            scan_cnt_d = '0;
            rd_vld_d   = 1'b0;
            match_d    = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        ram_re    = (scan_cnt_q < cnt_q);
        ram_raddr = scan_addr;
        rd_vld_d  = ram_re;
        if (ram_re) begin
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
        if (rd_vld_q && ram_rdata == {proc_q, ctx_q}) begin
          match_d = 1'b1;
        end
        if (!ram_re && !rd_vld_q) begin
          status_d = ST_OK;
          dup_d    = match_q;
          append_d = !match_q;
          state_d  = S_EMIT;
        end
      end

      S_DRAIN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rp_q;
        state_d   = S_DRAIN_WR;
      end

      S_DRAIN_WR: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = ST_OK;
          out_d.was_duplicate    = 1'b0;
          out_d.out_procedure    = ram_rdata[ENTRY_W-1:HANDLE_W];
          out_d.out_context      = ram_rdata[HANDLE_W-1:0];
          out_d.last_of_run      = (cnt_q == CNT_W'(1));
          out_d.pending_now      = PEND_W'(cnt_q - CNT_W'(1));
          out_d.total_queued     = tq_q;
          out_d.total_dispatched = td_q + TOTAL_W'(1);
          rp_d  = ptr_inc(rp_q);
          cnt_d = cnt_q - CNT_W'(1);
          td_d  = td_q + TOTAL_W'(1);
          state_d = (cnt_q == CNT_W'(1)) ? S_IDLE : S_DRAIN_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = status_q;
          out_d.was_duplicate    = dup_q;
          out_d.out_procedure    = '0;
          out_d.out_context      = '0;
          out_d.last_of_run      = 1'b1;
          out_d.pending_now      = PEND_W'(cnt_q);
          out_d.total_queued     = tq_q;
          out_d.total_dispatched = td_q;
          if (append_q) begin
            ram_we = 1'b1;
            wp_d   = ptr_inc(wp_q);
            cnt_d  = cnt_q + CNT_W'(1);
            tq_d   = tq_q + TOTAL_W'(1);
            out_d.pending_now  = PEND_W'(cnt_q + CNT_W'(1));
            out_d.total_queued = tq_q + TOTAL_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      tq_q        <= '0;
      td_q        <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      tq_q        <= tq_d;
      td_q        <= td_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_q   <= proc_d;
    ctx_q    <= ctx_d;
    status_q <= status_d;
    dup_q    <= dup_d;
    append_q <= append_d;
    out_q    <= out_d;
  end

  assign rsp.valid            = out_valid_q;
  assign rsp.status           = out_q.status;
  assign rsp.was_duplicate    = out_q.was_duplicate;
  assign rsp.out_procedure    = out_q.out_procedure;
  assign rsp.out_context      = out_q.out_context;
  assign rsp.last_of_run      = out_q.last_of_run;
  assign rsp.pending_now      = out_q.pending_now;
  assign rsp.total_queued     = out_q.total_queued;
  assign rsp.total_dispatched = out_q.total_dispatched;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> cnt_q < CNT_W'(QUEUE_DEPTH))
    else $error("append into a full queue");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and written in the same cycle");

  a_drain_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN_WR && out_free) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("drain transfer did not retire one entry");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_NONE) |-> (out_q.last_of_run && out_q.pending_now == '0))
    else $error("empty dispatch result malformed");

endmodule

// File: hw/rtl/dedup_deferred_call_fifo_top.sv
// A queue request that needs no duplicate check goes from idle straight to the emit state, which
// loads its result into the output register; with P entries pending, the scan state first reads
// and compares each of them. A dispatch alternates the drain read and drain write states per entry.
// Requests are handled one at a time; the next is accepted once the last result is registered.
// Reset (rst_ni, asynchronous, active low) clears pointers, pending count and lifetime totals;
// the entry store is not cleared, and only entries written since reset are ever read.
module dedup_deferred_call_fifo_top import ddcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddcf_req_if.sink   req_i,
  ddcf_rsp_if.source rsp_o
);

  // The controller owns the whole block: it holds the circular queue pointers and counters,
  // steps through the entry store one read per cycle while checking for a duplicate, and registers each result.
  //
  // A queue transfer is checked for a zero procedure and a priority level outside 4..31, then
  // for a full queue. If entries are pending, each is read from the store in FIFO order and
  // compared against the new pair; a hit drops the pair and reports it as a duplicate. The pair
  // is written at the write pointer in the same cycle that its result enters the output register.
  //
  // A dispatch transfer reads the oldest entry in the drain read state, takes the store data in the drain
  // write state and hands the entry to the output register, repeating until the queue is empty. The store read and the
  // output load alternate, so the dispatch rate is set by the store's registered read and by output back-pressure.
  //
  // The output register decouples the two sides: a result waits there while the controller
  // already prepares the next one, and a new request is accepted while a result is still waiting.
  ddcf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .rsp    (rsp_o)
  );

endmodule
